// ===== design/prt_pkg.sv =====
// Shared types and constants of the piece rarity tracker.
// No dependencies; every other file of the block imports it.
package prt_pkg;

    localparam int MAX_PIECES_DEF = 1024;
    localparam int MAX_PEERS_DEF  = 16;
    localparam int MAX_TOP_DEF    = 16;

    localparam int CNT_W = 5;
    localparam int LANES = 8;
    localparam int PC_W  = 11;
    localparam int PN_W  = 10;

    localparam logic [CNT_W-1:0] CNT_MAX  = 5'd31;
    localparam logic [PC_W-1:0]  PC_RESET = 11'd1024;

    typedef enum logic [1:0] {
        OP_WRITE  = 2'd0,
        OP_REMOVE = 2'd1,
        OP_QUERY  = 2'd2,
        OP_TOPN   = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_UPDATE,
        ST_QUERY,
        ST_SCAN,
        ST_EMIT
    } t_state;

    typedef logic [LANES*CNT_W-1:0] t_row;

endpackage

// ===== design/prt_ram.sv =====
// Single-port-write, single-port-read synchronous RAM with a registered read port.
// Used for the peer bitfield bytes and the rows of piece counts; uses prt_pkg.
module prt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048,
    parameter int AW    = 11
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    import prt_pkg::*;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/prt_scan.sv =====
// Rarest-piece search: folds one row of eight counts per cycle into a running best
// while i_merge is high. Uses prt_pkg for the row type.
module prt_scan #(
    parameter int RAW = 7,
    parameter int UW  = 11
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_clear,
    input  logic               i_merge,
    input  logic [RAW-1:0]     i_row,
    input  prt_pkg::t_row      i_data,
    input  logic [UW-1:0]      i_used,
    input  logic               i_first,
    input  logic [prt_pkg::CNT_W-1:0] i_prev_cnt,
    input  logic [RAW+2:0]     i_prev_idx,
    output logic [prt_pkg::CNT_W-1:0] o_best_cnt,
    output logic [RAW+2:0]     o_best_idx
);
    import prt_pkg::*;

    localparam int IW = RAW + 3;

    logic             r_found;
    logic [CNT_W-1:0] r_best_cnt;
    logic [IW-1:0]    r_best_idx;
    logic             n_found;
    logic [CNT_W-1:0] n_best_cnt;
    logic [IW-1:0]    n_best_idx;

    // lanes in ascending index order; strict less keeps the lower index on ties
    always_comb begin
        logic [CNT_W-1:0] c;
        logic [IW-1:0]    idx;
        logic             elig;
        n_found    = r_found;
        n_best_cnt = r_best_cnt;
        n_best_idx = r_best_idx;
        for (int k = 0; k < LANES; k++) begin
            c    = i_data[k*CNT_W +: CNT_W];
            idx  = {i_row, 3'(k)};
            elig = (int'(idx) < int'(i_used)) &&
                   (i_first || (c > i_prev_cnt) || ((c == i_prev_cnt) && (idx > i_prev_idx)));
            if (elig && (!n_found || (c < n_best_cnt))) begin
                n_found    = 1'b1;
                n_best_cnt = c;
                n_best_idx = idx;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else if (i_clear) begin
            r_found <= 1'b0;
        end else if (i_merge) begin
            r_found <= n_found;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_merge && !i_clear) begin
            r_best_cnt <= n_best_cnt;
            r_best_idx <= n_best_idx;
        end
    end

    assign o_best_cnt = r_best_cnt;
    assign o_best_idx = r_best_idx;

endmodule

// ===== design/piece_rarity_tracker_top_n_top.sv =====
// Piece rarity tracker, top level: availability counts, peer bitfields, top-N rarest.
// Depends on prt_pkg, prt_ram and prt_scan.
//
// Counts live in a RAM of rows of eight 5-bit counts, peer bytes in a byte RAM.
// After reset a clearing pass zeroes both RAMs over MAX_PEERS*ceil(MAX_PIECES/8)
// byte addresses (2048 by default); no item is accepted during it, configuration writes
// are. A write or remove reads, then writes back the byte and the eight counts of
// that row. A query reads the row, then waits for the output register. A top-N
// query makes one pass over the count RAM per result, one row of eight pieces per
// cycle, and each result then waits for the output register.
// Input is accepted only between items.
module piece_rarity_tracker_top_n_top #(
    parameter int MAX_PIECES = prt_pkg::MAX_PIECES_DEF,
    parameter int MAX_PEERS  = prt_pkg::MAX_PEERS_DEF,
    parameter int MAX_TOP    = prt_pkg::MAX_TOP_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [prt_pkg::PC_W-1:0] i_cfg_wdata,     // piece_count
    input  logic                     i_s_axis_tvalid,
    output logic                     o_s_axis_tready,
    // peer_slot[3:0], byte_index[10:4], bitfield_byte[18:11], piece_index[28:19],
    // count_wanted[33:29], zero[39:34]
    input  logic [39:0]              i_s_axis_tdata,
    input  logic [1:0]               i_s_axis_tuser,  // operation
    output logic                     o_m_axis_tvalid,
    input  logic                     i_m_axis_tready,
    // piece_number[9:0], availability[14:10], zero[15]
    output logic [15:0]              o_m_axis_tdata,
    output logic                     o_m_axis_tlast
);
    import prt_pkg::*;

    localparam int BPP = (MAX_PIECES + 7) / 8;
    localparam int RAW = (BPP > 1) ? $clog2(BPP) : 1;
    localparam int IW  = RAW + 3;
    localparam int BFD = MAX_PEERS * BPP;
    localparam int BAW = (BFD > 1) ? $clog2(BFD) : 1;
    localparam int UW  = $clog2(MAX_PIECES + 1);
    localparam int NW  = $clog2(MAX_TOP + 1);

    // input fields
    t_op        in_op;
    logic [3:0] in_slot;
    logic [6:0] in_bidx;
    logic [7:0] in_bits;
    logic [9:0] in_pidx;
    logic [4:0] in_want;
    logic       acc;
    logic       in_ok;
    int         want_i;

    assign in_op   = t_op'(i_s_axis_tuser);
    assign in_slot = i_s_axis_tdata[3:0];
    assign in_bidx = i_s_axis_tdata[10:4];
    assign in_bits = i_s_axis_tdata[18:11];
    assign in_pidx = i_s_axis_tdata[28:19];
    assign in_want = i_s_axis_tdata[33:29];

    t_state r_state, n_state;

    logic [PC_W-1:0]  r_pc;
    logic [UW-1:0]    used;
    logic [RAW-1:0]   last_row;
    logic [BAW-1:0]   r_clr;
    logic             r_out_vld;
    logic [PN_W-1:0]  r_out_pn;
    logic [CNT_W-1:0] r_out_av;
    logic             r_out_last;
    logic             out_free;

    // latched item
    t_op              r_op;
    logic [7:0]       r_bits;
    logic [9:0]       r_pidx;
    logic [BAW-1:0]   r_bf_addr;
    logic [RAW-1:0]   r_cnt_addr;
    logic [NW-1:0]    r_n;
    logic [NW-1:0]    r_rank;

    // scan control
    logic             r_issuing;
    logic             r_dvld;
    logic [RAW-1:0]   r_row;
    logic [RAW-1:0]   r_drow;
    logic [CNT_W-1:0] r_prev_cnt;
    logic [IW-1:0]    r_prev_idx;
    logic             rank_last;
    logic             scan_start;

    // memory ports
    logic             bf_we, bf_re, cnt_we, cnt_re;
    logic [BAW-1:0]   bf_waddr, bf_raddr;
    logic [7:0]       bf_wdata, bf_rdata;
    logic [RAW-1:0]   cnt_waddr, cnt_raddr;
    t_row             cnt_wdata, cnt_rdata;
    logic             out_load;
    logic [PN_W-1:0]  out_pn;
    logic [CNT_W-1:0] out_av;
    logic             out_last;
    logic [CNT_W-1:0] best_cnt;
    logic [IW-1:0]    best_idx;
    t_row             upd_row;

    assign used     = (int'(r_pc) > MAX_PIECES) ? UW'(MAX_PIECES) : UW'(r_pc);
    assign last_row = RAW'((int'(used) - 1) >> 3);
    assign out_free = !r_out_vld || i_m_axis_tready;
    assign acc      = i_s_axis_tvalid && o_s_axis_tready;
    assign in_ok    = (int'(in_slot) < MAX_PEERS) && (int'(in_bidx) < BPP);
    assign rank_last = (int'(r_rank) + 1 == int'(r_n));

    always_comb begin
        want_i = int'(in_want);
        if (want_i > MAX_TOP) begin
            want_i = MAX_TOP;
        end
        if (want_i > int'(used)) begin
            want_i = int'(used);
        end
    end

    // count update: drop the old byte's bits, then add the new byte's bits
    always_comb begin
        logic [7:0]       nb;
        logic [CNT_W-1:0] c;
        nb = (r_op == OP_WRITE) ? r_bits : 8'd0;
        for (int k = 0; k < LANES; k++) begin
            c = cnt_rdata[k*CNT_W +: CNT_W];
            if (bf_rdata[k] && (c != '0)) begin
                c = c - 1'b1;
            end
            if (nb[k] && (c != CNT_MAX)) begin
                c = c + 1'b1;
            end
            upd_row[k*CNT_W +: CNT_W] = c;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (r_clr == BAW'(BFD - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (acc) begin
                    unique case (in_op)
                        OP_WRITE, OP_REMOVE: n_state = in_ok ? ST_UPDATE : ST_IDLE;
                        OP_QUERY:            n_state = ST_QUERY;
                        OP_TOPN:             n_state = (want_i == 0) ? ST_IDLE : ST_SCAN;
                        default:             n_state = ST_IDLE;
                    endcase
                end
            end
            ST_UPDATE: n_state = ST_IDLE;
            ST_QUERY: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            ST_SCAN: begin
                if (!r_issuing && !r_dvld) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    n_state = rank_last ? ST_IDLE : ST_SCAN;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs of the controller
    always_comb begin
        bf_we     = 1'b0;
        bf_waddr  = r_bf_addr;
        bf_wdata  = 8'd0;
        bf_re     = 1'b0;
        bf_raddr  = BAW'(int'(in_slot) * BPP + int'(in_bidx));
        cnt_we    = 1'b0;
        cnt_waddr = r_cnt_addr;
        cnt_wdata = upd_row;
        cnt_re    = 1'b0;
        cnt_raddr = (in_op == OP_QUERY) ? RAW'(in_pidx >> 3) : RAW'(in_bidx);
        out_load  = 1'b0;
        out_pn    = r_pidx;
        out_av    = '0;
        out_last  = 1'b1;
        o_s_axis_tready = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                bf_we     = 1'b1;
                bf_waddr  = r_clr;
                cnt_we    = int'(r_clr) < BPP;
                cnt_waddr = RAW'(r_clr);
                cnt_wdata = '0;
            end
            ST_IDLE: begin
                o_s_axis_tready = 1'b1;
                bf_re  = acc;
                cnt_re = acc;
            end
            ST_UPDATE: begin
                bf_we    = 1'b1;
                bf_wdata = (r_op == OP_WRITE) ? r_bits : 8'd0;
                cnt_we   = 1'b1;
            end
            ST_QUERY: begin
                out_load = out_free;
                if (int'(r_pidx) < int'(used)) begin
                    out_av = cnt_rdata[r_pidx[2:0]*CNT_W +: CNT_W];
                end
            end
            ST_SCAN: begin
                cnt_re    = r_issuing;
                cnt_raddr = r_row;
            end
            ST_EMIT: begin
                out_load = out_free;
                out_pn   = PN_W'(best_idx);
                out_av   = best_cnt;
                out_last = rank_last;
            end
            default: ;
        endcase
    end

    assign scan_start = (n_state == ST_SCAN) && (r_state != ST_SCAN);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_clr     <= '0;
            r_pc      <= PC_RESET;
            r_out_vld <= 1'b0;
            r_issuing <= 1'b0;
            r_dvld    <= 1'b0;
            r_rank    <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
            if (i_cfg_we) begin
                r_pc <= i_cfg_wdata;
            end
            if (out_load) begin
                r_out_vld <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
            // walk the rows: issue one read a cycle, the data follows in the next cycle
            if (scan_start) begin
                r_issuing <= 1'b1;
                r_dvld    <= 1'b0;
            end else if (r_state == ST_SCAN) begin
                r_dvld <= r_issuing;
                if (r_issuing && (r_row == last_row)) begin
                    r_issuing <= 1'b0;
                end
            end else begin
                r_dvld <= 1'b0;
            end
            if (acc) begin
                r_rank <= '0;
            end else if ((r_state == ST_EMIT) && out_free) begin
                r_rank <= r_rank + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_op       <= in_op;
            r_bits     <= in_bits;
            r_pidx     <= in_pidx;
            r_bf_addr  <= bf_raddr;
            r_cnt_addr <= cnt_raddr;
            r_n        <= NW'(want_i);
        end
        if (scan_start) begin
            r_row <= '0;
        end else if ((r_state == ST_SCAN) && r_issuing && (r_row != last_row)) begin
            r_row <= r_row + 1'b1;
        end
        if (r_state == ST_SCAN) begin
            r_drow <= r_row;
        end
        if ((r_state == ST_EMIT) && out_free) begin
            r_prev_cnt <= best_cnt;
            r_prev_idx <= best_idx;
        end
        if (out_load) begin
            r_out_pn   <= out_pn;
            r_out_av   <= out_av;
            r_out_last <= out_last;
        end
    end

    prt_ram #(
        .WIDTH (8),
        .DEPTH (BFD),
        .AW    (BAW)
    ) u_bf_ram (
        .i_clk   (i_clk),
        .i_we    (bf_we),
        .i_waddr (bf_waddr),
        .i_wdata (bf_wdata),
        .i_re    (bf_re),
        .i_raddr (bf_raddr),
        .o_rdata (bf_rdata)
    );

    prt_ram #(
        .WIDTH (LANES*CNT_W),
        .DEPTH (BPP),
        .AW    (RAW)
    ) u_cnt_ram (
        .i_clk   (i_clk),
        .i_we    (cnt_we),
        .i_waddr (cnt_waddr),
        .i_wdata (cnt_wdata),
        .i_re    (cnt_re),
        .i_raddr (cnt_raddr),
        .o_rdata (cnt_rdata)
    );

    prt_scan #(
        .RAW (RAW),
        .UW  (UW)
    ) u_scan (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_clear    (scan_start),
        .i_merge    (r_dvld),
        .i_row      (r_drow),
        .i_data     (cnt_rdata),
        .i_used     (used),
        .i_first    (r_rank == '0),
        .i_prev_cnt (r_prev_cnt),
        .i_prev_idx (r_prev_idx),
        .o_best_cnt (best_cnt),
        .o_best_idx (best_idx)
    );

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = {1'b0, r_out_av, r_out_pn};
    assign o_m_axis_tlast  = r_out_last;

endmodule

// ===== test/tb.sv =====
// Testbench for the piece rarity tracker: random and directed byte writes, removes,
// count queries and top-N rarest queries, checked against an in-bench predictor.
// Depends on prt_pkg and piece_rarity_tracker_top_n_top.
`timescale 1ns / 100ps

module tb;
    import prt_pkg::*;

    localparam int NPIECE = 1024;
    localparam int NPEER  = 16;
    localparam int NTOP   = 16;
    localparam int NBYTE  = NPIECE / 8;
    localparam longint CYCLE_LIMIT = 3000000;

    typedef struct packed {
        t_op        op;
        logic [39:0] data;
    } t_item;

    typedef struct packed {
        logic [9:0] piece;
        logic [4:0] avail;
        logic       last;
    } t_answer;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [10:0] i_cfg_wdata;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    logic [39:0] i_s_axis_tdata;
    logic [1:0]  i_s_axis_tuser;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    logic [15:0] o_m_axis_tdata;
    logic        o_m_axis_tlast;

    piece_rarity_tracker_top_n_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    // predictor state
    logic [4:0]  avail_cnt [NPIECE];
    logic [7:0]  have_byte [NPEER*NBYTE];
    logic [10:0] pieces_used;

    t_item   pending_items[$];
    t_answer expected_answers[$];
    int      mismatches;
    int      answers_seen;
    int      items_sent;
    longint  cycle_cnt;
    bit      hold_sender;
    int      burst_left;
    int      gap_left;
    int      stall_phase;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic void queue_item(t_item it);
        pending_items.insert(pending_items.size(), it);
    endfunction

    function automatic void queue_answer(t_answer a);
        expected_answers.insert(expected_answers.size(), a);
    endfunction

    function automatic int used_pieces();
        return (pieces_used > NPIECE) ? NPIECE : int'(pieces_used);
    endfunction

    function automatic void apply_byte(int bidx, logic [7:0] bits, bit add);
        int p;
        for (int k = 0; k < 8; k++) begin
            p = bidx * 8 + k;
            if (bits[k]) begin
                if (add && avail_cnt[p] != 5'd31) avail_cnt[p]++;
                else if (!add && avail_cnt[p] != 5'd0) avail_cnt[p]--;
            end
        end
    endfunction

    // advance the predictor by one accepted item, queue its answers
    function automatic void predict_item(t_item it);
        logic [3:0] slot;
        logic [6:0] bidx;
        logic [7:0] bits;
        logic [9:0] pidx;
        logic [4:0] want;
        int n, used, pos, best_c, best_i, prev_c, prev_i, c;
        bit found;
        t_answer a;
        slot = it.data[3:0];
        bidx = it.data[10:4];
        bits = it.data[18:11];
        pidx = it.data[28:19];
        want = it.data[33:29];
        used = used_pieces();
        case (it.op)
            OP_WRITE, OP_REMOVE: begin
                pos = int'(slot) * NBYTE + int'(bidx);
                apply_byte(bidx, have_byte[pos], 1'b0);
                if (it.op == OP_WRITE) begin
                    have_byte[pos] = bits;
                    apply_byte(bidx, bits, 1'b1);
                end else begin
                    have_byte[pos] = 8'd0;
                end
            end
            OP_QUERY: begin
                a.piece = pidx;
                a.avail = (int'(pidx) < used) ? avail_cnt[pidx] : 5'd0;
                a.last  = 1'b1;
                queue_answer(a);
            end
            default: begin
                n = want;
                if (n > NTOP) n = NTOP;
                if (n > used) n = used;
                prev_c = 0;
                prev_i = 0;
                for (int r = 0; r < n; r++) begin
                    found = 0;
                    best_c = 0;
                    best_i = 0;
                    for (int i = 0; i < used; i++) begin
                        c = avail_cnt[i];
                        if (r > 0 && (c < prev_c || (c == prev_c && i <= prev_i))) continue;
                        if (!found || c < best_c) begin
                            best_c = c;
                            best_i = i;
                            found = 1;
                        end
                    end
                    prev_c = best_c;
                    prev_i = best_i;
                    a.piece = best_i[9:0];
                    a.avail = best_c[4:0];
                    a.last  = (r + 1 == n);
                    queue_answer(a);
                end
            end
        endcase
    endfunction

    function automatic t_item make_item(t_op op, int slot, int bidx, int bits,
                                        int pidx, int want);
        t_item it;
        it.op = op;
        it.data = '0;
        it.data[3:0]   = slot[3:0];
        it.data[10:4]  = bidx[6:0];
        it.data[18:11] = bits[7:0];
        it.data[28:19] = pidx[9:0];
        it.data[33:29] = want[4:0];
        return it;
    endfunction

    // writes most often, in a small window so the counts pile up and top-N sees ties
    function automatic t_item random_item();
        int sel, bidx;
        t_item it;
        sel = $urandom_range(0, 99);
        bidx = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 7);
        if (sel < 45)
            it = make_item(OP_WRITE, $urandom_range(0, 15), bidx, $urandom_range(0, 255),
                           $urandom_range(0, 1023), $urandom_range(0, 31));
        else if (sel < 60)
            it = make_item(OP_REMOVE, $urandom_range(0, 15), bidx, $urandom_range(0, 255),
                           $urandom_range(0, 1023), $urandom_range(0, 31));
        else if (sel < 85)
            it = make_item(OP_QUERY, $urandom_range(0, 15), bidx, $urandom_range(0, 255),
                           ($urandom_range(0, 1) ? $urandom_range(0, 63)
                                                 : $urandom_range(0, 1023)),
                           $urandom_range(0, 31));
        else
            it = make_item(OP_TOPN, $urandom_range(0, 15), bidx, $urandom_range(0, 255),
                           $urandom_range(0, 1023),
                           ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31)
                                                       : $urandom_range(0, 6));
        it.data[39:34] = '0;
        return it;
    endfunction

    task automatic drain();
        while (pending_items.size() != 0 || expected_answers.size() != 0)
            @(posedge i_clk);
        // let a trailing write settle before touching the register
        repeat (20) @(posedge i_clk);
    endtask

    task automatic set_piece_count(int value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value[10:0];
        pieces_used = value[10:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic run_random(int count);
        for (int i = 0; i < count; i++) queue_item(random_item());
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                predict_item(pending_items.pop_front());
                items_sent++;
            end
            if (pending_items.size() != 0 && !(i_s_axis_tvalid && !o_s_axis_tready)) begin
                if (hold_sender && expected_answers.size() != 0) begin
                    i_s_axis_tvalid <= 1'b0;
                end else if (gap_left > 0) begin
                    gap_left--;
                    i_s_axis_tvalid <= 1'b0;
                end else begin
                    if (burst_left == 0) begin
                        burst_left = $urandom_range(1, 12);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                    burst_left--;
                    i_s_axis_tvalid <= 1'b1;
                    i_s_axis_tdata  <= pending_items[0].data;
                    i_s_axis_tuser  <= pending_items[0].op;
                end
            end else if (!(i_s_axis_tvalid && !o_s_axis_tready)) begin
                i_s_axis_tvalid <= 1'b0;
            end
        end
    end

    // monitor and receiver stall pattern
    always @(posedge i_clk) begin
        t_answer a;
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("CHECKS FAILED");
            $finish;
        end
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            answers_seen++;
            if (expected_answers.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected answer piece=%0d avail=%0d last=%0b",
                             o_m_axis_tdata[9:0], o_m_axis_tdata[14:10], o_m_axis_tlast);
            end else begin
                a = expected_answers.pop_front();
                if (o_m_axis_tdata[9:0] !== a.piece || o_m_axis_tdata[14:10] !== a.avail
                    || o_m_axis_tlast !== a.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected piece=%0d avail=%0d last=%0b, got %0d %0d %0b",
                                 a.piece, a.avail, a.last, o_m_axis_tdata[9:0],
                                 o_m_axis_tdata[14:10], o_m_axis_tlast);
                end
            end
        end
        stall_phase = (stall_phase + 1) % 64;
        if (stall_phase < 20) i_m_axis_tready <= 1'b1;
        else i_m_axis_tready <= (stall_phase % 5 != 0) && ($urandom_range(0, 3) != 0);
    end

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata = '0;
        i_s_axis_tuser = '0;
        i_m_axis_tready = 1'b0;
        mismatches = 0;
        answers_seen = 0;
        items_sent = 0;
        cycle_cnt = 0;
        hold_sender = 0;
        burst_left = 0;
        gap_left = 0;
        stall_phase = 0;
        pieces_used = PC_RESET;
        for (int i = 0; i < NPIECE; i++) avail_cnt[i] = '0;
        for (int i = 0; i < NPEER*NBYTE; i++) have_byte[i] = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, every operation, out-of-range and top-N edge sizes
        queue_item(make_item(OP_TOPN, 0, 0, 0, 0, 16));
        queue_item(make_item(OP_WRITE, 0, 0, 8'hFF, 0, 0));
        queue_item(make_item(OP_WRITE, 15, 127, 8'hFF, 1023, 31));
        queue_item(make_item(OP_WRITE, 15, 127, 8'h80, 1023, 31));
        queue_item(make_item(OP_WRITE, 3, 0, 8'h0F, 0, 0));
        queue_item(make_item(OP_QUERY, 0, 0, 0, 0, 0));
        queue_item(make_item(OP_QUERY, 0, 0, 0, 1023, 0));
        queue_item(make_item(OP_QUERY, 0, 0, 0, 1016, 0));
        queue_item(make_item(OP_TOPN, 0, 0, 0, 0, 0));
        queue_item(make_item(OP_TOPN, 0, 0, 0, 0, 31));
        queue_item(make_item(OP_TOPN, 0, 0, 0, 0, 1));
        queue_item(make_item(OP_REMOVE, 3, 0, 8'hFF, 0, 0));
        queue_item(make_item(OP_REMOVE, 3, 0, 0, 0, 0));
        queue_item(make_item(OP_QUERY, 0, 0, 0, 2, 0));
        // piece 8: a write from each of the 16 peers raises its count to 16, below saturation
        for (int s = 0; s < 16; s++)
            queue_item(make_item(OP_WRITE, s, 1, 8'h01, 0, 0));
        queue_item(make_item(OP_QUERY, 0, 0, 0, 8, 0));
        drain();

        // small piece count: out-of-use queries and top-N clipped by pieces in use
        set_piece_count(1);
        queue_item(make_item(OP_QUERY, 0, 0, 0, 1, 0));
        queue_item(make_item(OP_TOPN, 0, 0, 0, 0, 16));
        run_random(40);
        drain();

        set_piece_count(13);
        run_random(35);
        drain();

        set_piece_count(2047);
        hold_sender = 1;
        run_random(20);
        drain();
        hold_sender = 0;

        set_piece_count(0);
        queue_item(make_item(OP_TOPN, 0, 0, 0, 0, 5));
        queue_item(make_item(OP_QUERY, 0, 0, 0, 0, 0));
        drain();

        set_piece_count(1024);
        run_random(40);
        drain();

        set_piece_count(40);
        run_random(40);
        drain();

        $display("sent %0d items, checked %0d answers across piece counts 0..2047",
                 items_sent, answers_seen);
        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
